FILE: design/pds_pkg.sv
`timescale 1ns / 1ps
package pds_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned RefW      = 28;
  localparam int unsigned HzW       = 32;
  localparam int unsigned FbW       = 10;
  localparam int unsigned RdW       = 8;
  localparam int unsigned StepW     = RefW + 1;
  localparam int unsigned DivNumW   = HzW + 1;
  localparam int unsigned ProdW     = HzW + 4;
  localparam int unsigned FpllW     = StepW + FbW;

  localparam logic [CfgIdxW-1:0] RegRefHz      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVcoLow     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVcoHigh    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFbMin      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFbMax      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRdMin      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRdMax      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegVariant    = 3'd7;

  localparam logic [RefW-1:0] RstRefHz   = 28'd24000000;
  localparam logic [HzW-1:0]  RstVcoLow  = 32'd6000000;
  localparam logic [HzW-1:0]  RstVcoHigh = 32'd320000000;
  localparam logic [FbW-1:0]  RstFbMin   = 10'd12;
  localparam logic [FbW-1:0]  RstFbMax   = 10'd519;
  localparam logic [RdW-1:0]  RstRdMin   = 8'd3;
  localparam logic [RdW-1:0]  RstRdMax   = 8'd129;

  localparam logic [2:0] DefaultSCode = 3'd1;

  function automatic logic [3:0] div_of_code(input logic variant, input logic [2:0] code);
    logic [3:0] d;
    case (code)
      3'd0: d = 4'd10;
      3'd1: d = 4'd2;
      3'd2: d = 4'd8;
      3'd3: d = 4'd4;
      3'd4: d = 4'd5;
      3'd5: d = 4'd7;
      3'd6: d = variant ? 4'd9 : 4'd3;
      default: d = 4'd6;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] code_by_rank(input logic variant, input logic [2:0] rank);
    logic [2:0] c;
    case (rank)
      3'd0: c = 3'd1;
      3'd1: c = variant ? 3'd3 : 3'd6;
      3'd2: c = variant ? 3'd4 : 3'd3;
      3'd3: c = variant ? 3'd7 : 3'd4;
      3'd4: c = variant ? 3'd5 : 3'd7;
      3'd5: c = variant ? 3'd2 : 3'd5;
      3'd6: c = variant ? 3'd6 : 3'd2;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  typedef enum logic [3:0] {
    StIdle, StScan, StRdTest, StDiv1, StStep, StDiv2, StChk, StEval, StRdNext, StFinish
  } state_e;

  typedef struct packed {
    logic start;
    logic s_step;
    logic s_take;
    logic div1_start;
    logic div2_start;
    logic step_take;
    logic vd_take;
    logic mul_take;
    logic eval;
    logic rd_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic s_fit;
    logic s_last;
    logic rd_over;
    logic rd_zero;
    logic div_done;
    logic step_zero;
    logic vd_fits;
    logic better;
    logic exact;
    logic out_free;
  } status_t;

endpackage

FILE: design/pds_div.sv
`timescale 1ns / 1ps
module pds_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pds_pkg::DivNumW-1:0]   num_i,
  input  logic [pds_pkg::StepW-1:0]     den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [pds_pkg::DivNumW-1:0]   quot_o
);
  localparam int unsigned NW = pds_pkg::DivNumW;
  localparam int unsigned DW = pds_pkg::StepW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;
endmodule

FILE: design/pds_datapath.sv
`timescale 1ns / 1ps
module pds_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pds_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pds_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [pds_pkg::HzW-1:0]        target_i,
  input  logic                           m_ready_i,
  input  pds_pkg::cmd_t                  cmd_i,
  output pds_pkg::status_t               status_o,
  output logic                           div_busy_o,
  output logic                           m_valid_o,
  output logic [2:0]                     out_div_code_o,
  output logic [pds_pkg::FbW-1:0]        vco_code_o,
  output logic [pds_pkg::RdW-1:0]        ref_code_o
);
  logic [pds_pkg::RefW-1:0] ref_hz_q;
  logic [pds_pkg::HzW-1:0]  vco_low_q, vco_high_q;
  logic [pds_pkg::FbW-1:0]  fb_min_q, fb_max_q;
  logic [pds_pkg::RdW-1:0]  rd_min_q, rd_max_q;
  logic                     variant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_hz_q   <= pds_pkg::RstRefHz;
      vco_low_q  <= pds_pkg::RstVcoLow;
      vco_high_q <= pds_pkg::RstVcoHigh;
      fb_min_q   <= pds_pkg::RstFbMin;
      fb_max_q   <= pds_pkg::RstFbMax;
      rd_min_q   <= pds_pkg::RstRdMin;
      rd_max_q   <= pds_pkg::RstRdMax;
      variant_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pds_pkg::RegRefHz:   ref_hz_q   <= cfg_data_i[pds_pkg::RefW-1:0];
        pds_pkg::RegVcoLow:  vco_low_q  <= cfg_data_i;
        pds_pkg::RegVcoHigh: vco_high_q <= cfg_data_i;
        pds_pkg::RegFbMin:   fb_min_q   <= cfg_data_i[pds_pkg::FbW-1:0];
        pds_pkg::RegFbMax:   fb_max_q   <= cfg_data_i[pds_pkg::FbW-1:0];
        pds_pkg::RegRdMin:   rd_min_q   <= cfg_data_i[pds_pkg::RdW-1:0];
        pds_pkg::RegRdMax:   rd_max_q   <= cfg_data_i[pds_pkg::RdW-1:0];
        pds_pkg::RegVariant: variant_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [pds_pkg::HzW-1:0]     target_q, f_q;
  logic [2:0]                  idx_q, s_code_q, res_s_q;
  logic [pds_pkg::RdW:0]       rd_q;
  logic [pds_pkg::StepW-1:0]   step_q;
  logic [pds_pkg::DivNumW-1:0] vd_q;
  logic [pds_pkg::FpllW-1:0]   fpll_q, diff, best_q;
  logic                        have_q;
  logic [pds_pkg::FbW-1:0]     vco_q, res_vco_q;
  logic [pds_pkg::RdW-1:0]     rcode_q, res_ref_q;
  logic                        out_valid_q;
  logic [2:0]                  code;
  logic [pds_pkg::ProdW-1:0]   prod;
  logic                        s_fit, better;
  logic                        div_start, div_done;
  logic [pds_pkg::DivNumW-1:0] div_num, quot;
  logic [pds_pkg::StepW-1:0]   div_den;
  logic [pds_pkg::FpllW-1:0]   f_ext;

  assign code  = pds_pkg::code_by_rank(variant_q, idx_q);
  assign prod  = pds_pkg::ProdW'(target_q) * pds_pkg::ProdW'(pds_pkg::div_of_code(variant_q, code));
  assign s_fit = (prod > pds_pkg::ProdW'(vco_low_q)) && (prod <= pds_pkg::ProdW'(vco_high_q));

  assign div_start = cmd_i.div1_start | cmd_i.div2_start;
  assign div_num   = cmd_i.div1_start
                   ? pds_pkg::DivNumW'({ref_hz_q, 1'b0})
                   : pds_pkg::DivNumW'(f_q) + pds_pkg::DivNumW'(step_q >> 1);
  assign div_den   = cmd_i.div1_start ? pds_pkg::StepW'(rd_q[pds_pkg::RdW-1:0]) : step_q;

  pds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy_o),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign f_ext  = pds_pkg::FpllW'(f_q);
  assign diff   = (fpll_q >= f_ext) ? fpll_q - f_ext : f_ext - fpll_q;
  assign better = !have_q || (diff < best_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= target_i;
      idx_q    <= '0;
      s_code_q <= pds_pkg::DefaultSCode;
      vco_q    <= fb_max_q;
      rcode_q  <= rd_max_q;
    end
    if (cmd_i.s_step) idx_q <= idx_q + 3'd1;
    if (cmd_i.s_take) begin
      f_q      <= prod[pds_pkg::HzW-1:0];
      s_code_q <= code;
      rd_q     <= {1'b0, rd_min_q};
    end
    if (cmd_i.rd_inc)    rd_q   <= rd_q + 1'b1;
    if (cmd_i.step_take) step_q <= quot[pds_pkg::StepW-1:0];
    if (cmd_i.vd_take)   vd_q   <= quot;
    if (cmd_i.mul_take)
      fpll_q <= pds_pkg::FpllW'(step_q) * pds_pkg::FpllW'(vd_q[pds_pkg::FbW-1:0]);
    if (cmd_i.eval && better) begin
      vco_q   <= vd_q[pds_pkg::FbW-1:0] - pds_pkg::FbW'(8);
      rcode_q <= rd_q[pds_pkg::RdW-1:0] - pds_pkg::RdW'(2);
      best_q  <= diff;
    end
    if (cmd_i.out_load) begin
      res_s_q   <= s_code_q;
      res_vco_q <= vco_q;
      res_ref_q <= rcode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) have_q <= 1'b0;
      else if (cmd_i.eval && better) have_q <= 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.s_fit     = s_fit;
  assign status_o.s_last    = idx_q == 3'd7;
  assign status_o.rd_over   = rd_q > {1'b0, rd_max_q};
  assign status_o.rd_zero   = rd_q == '0;
  assign status_o.div_done  = div_done;
  assign status_o.step_zero = step_q == '0;
  assign status_o.vd_fits   = (vd_q >= pds_pkg::DivNumW'(fb_min_q))
                           && (vd_q <= pds_pkg::DivNumW'(fb_max_q));
  assign status_o.better    = better;
  assign status_o.exact     = diff == '0;
  assign status_o.out_free  = !out_valid_q || m_ready_i;

  assign m_valid_o      = out_valid_q;
  assign out_div_code_o = res_s_q;
  assign vco_code_o     = res_vco_q;
  assign ref_code_o     = res_ref_q;
endmodule

FILE: design/pds_ctrl.sv
`timescale 1ns / 1ps
module pds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pds_pkg::status_t  status_i,
  output pds_pkg::cmd_t     cmd_o,
  output pds_pkg::state_e   state_o
);
  pds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pds_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::StIdle:   if (in_valid_i) state_d = pds_pkg::StScan;
      pds_pkg::StScan: begin
        if (status_i.s_fit)       state_d = pds_pkg::StRdTest;
        else if (status_i.s_last) state_d = pds_pkg::StFinish;
      end
      pds_pkg::StRdTest: begin
        if (status_i.rd_over)      state_d = pds_pkg::StFinish;
        else if (status_i.rd_zero) state_d = pds_pkg::StRdNext;
        else                       state_d = pds_pkg::StDiv1;
      end
      pds_pkg::StDiv1:   if (status_i.div_done) state_d = pds_pkg::StStep;
      pds_pkg::StStep:   state_d = status_i.step_zero ? pds_pkg::StRdNext : pds_pkg::StDiv2;
      pds_pkg::StDiv2:   if (status_i.div_done) state_d = pds_pkg::StChk;
      pds_pkg::StChk:    state_d = status_i.vd_fits ? pds_pkg::StEval : pds_pkg::StRdNext;
      pds_pkg::StEval:   state_d = (status_i.better && status_i.exact)
                                 ? pds_pkg::StFinish : pds_pkg::StRdNext;
      pds_pkg::StRdNext: state_d = pds_pkg::StRdTest;
      pds_pkg::StFinish: if (status_i.out_free) state_d = pds_pkg::StIdle;
      default:           state_d = pds_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pds_pkg::StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      pds_pkg::StScan: begin
        cmd_o.s_take = status_i.s_fit;
        cmd_o.s_step = !status_i.s_fit;
      end
      pds_pkg::StRdTest: cmd_o.div1_start = !status_i.rd_over && !status_i.rd_zero;
      pds_pkg::StDiv1:   cmd_o.step_take  = status_i.div_done;
      pds_pkg::StStep:   cmd_o.div2_start = !status_i.step_zero;
      pds_pkg::StDiv2:   cmd_o.vd_take    = status_i.div_done;
      pds_pkg::StChk:    cmd_o.mul_take   = status_i.vd_fits;
      pds_pkg::StEval:   cmd_o.eval       = 1'b1;
      pds_pkg::StRdNext: cmd_o.rd_inc     = 1'b1;
      pds_pkg::StFinish: cmd_o.out_load   = status_i.out_free;
      default: ;
    endcase
  end

  assign state_o = state_q;
endmodule

FILE: design/pll_divider_search_top.sv
`timescale 1ns / 1ps
// Picks output, reference and feedback divider codes for a clock synthesizer from a
// wanted frequency. One request at a time: up to eight output divider codes are scanned,
// then each reference divider from refdiv_min to refdiv_max takes up to two waits on
// the shared 33-step bit-serial divider, plus five control steps for the range test,
// step check, fit check, compare and advance; an exact match ends the search early.
// A finished result sits in an output register, so the next request is taken
// while it waits. Configuration writes are taken every cycle.
module pll_divider_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] target_hz
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [2:0] out_div_code, [12:3] vco_code, [20:13] ref_code
);
  pds_pkg::cmd_t    cmd;
  pds_pkg::status_t status;
  pds_pkg::state_e  state;
  logic             div_busy;
  logic [2:0]       s_code;
  logic [9:0]       vco_code;
  logic [7:0]       ref_code;

  assign cfg_ready_o = 1'b1;

  pds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  pds_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .target_i       (s_axis_tdata_i),
    .m_ready_i      (m_axis_tready_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .div_busy_o     (div_busy),
    .m_valid_o      (m_axis_tvalid_o),
    .out_div_code_o (s_code),
    .vco_code_o     (vco_code),
    .ref_code_o     (ref_code)
  );

  assign m_axis_tdata_o = {3'b000, ref_code, vco_code, s_code};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while search running");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == pds_pkg::StIdle |-> !div_busy)
    else $error("divider busy while idle");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten");
`endif
endmodule
